>>> hw/rtl/mbbc_pkg.sv
package mbbc_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_MASK_COLOR   = 2'd2;

	// Request function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// Result kind codes
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_PIXEL   = 1'b1;

	// Read status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] pixel_in;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic       found;
		logic [8:0] crop_width;
		logic [8:0] crop_height;
		logic [7:0] pixel_out;
		logic       last;
		logic       status;
	} res_t;

	// Frame state seen by the read side
	typedef struct packed {
		logic any_found;
		logic frame_ready;
	} box_stat_t;

	// Outcome of one load
	typedef struct packed {
		logic       frame_end;
		logic       found;
		logic [8:0] crop_width;
		logic [8:0] crop_height;
	} load_sum_t;

endpackage

>>> hw/rtl/masked_bounding_box_crop_top.sv
// Masked bounding-box crop. Loads (func 0) write one raster pixel each into a
// synchronous frame RAM of MAX_WIDTH*MAX_HEIGHT bytes while the box of
// non-mask pixels is tracked; the last load of a frame returns the summary.
// Reads (func 1) walk the cropped rectangle in raster order, one RAM read
// each while a found box is ready. Every request is accepted, so busy stays
// low and a new request may start in every cycle. A result, when the request
// produces one, appears on result for exactly one cycle with done high, in
// the cycle after the request was taken, registered to match the RAM's read
// port. The receiver cannot stall, so it must take every strobe. The RAM is
// not cleared after reset; reading a cell never written returns junk.
module masked_bounding_box_crop_top import mbbc_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	output logic       done,
	output res_t       result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [8:0]    image_width_q, image_height_q;
	logic [7:0]    mask_color_q;
	logic [CW:0]   w_eff, crop_w;
	logic [RW:0]   h_eff, crop_h;
	logic [CW-1:0] min_col, read_col_q;
	logic [RW-1:0] min_row, read_row_q;
	logic          read_done_q;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    rdata;
	box_stat_t     stat;
	load_sum_t     sum;
	logic          accept, load, rd, rd_ok, col_end, row_end;
	logic          done_s1, pix_s1;
	res_t          res_nxt;
	res_t          res_s1;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign load      = accept && (req.func == FUNC_LOAD);
	assign rd        = accept && (req.func == FUNC_READ);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 9'd256;
			image_height_q <= 9'd256;
			mask_color_q   <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				CFG_MASK_COLOR:   mask_color_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Effective frame size, clamped to 1..MAX
	always_comb begin
		if (image_width_q == '0) w_eff = (CW+1)'(1);
		else if (32'(image_width_q) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
		else w_eff = (CW+1)'(image_width_q);
		if (image_height_q == '0) h_eff = (RW+1)'(1);
		else if (32'(image_height_q) > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
		else h_eff = (RW+1)'(image_height_q);
	end

	mbbc_box #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.CW        (CW),
		.RW        (RW),
		.AW        (AW)
	) u_box (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.pixel  (req.pixel_in),
		.mask   (mask_color_q),
		.w_eff  (w_eff),
		.h_eff  (h_eff),
		.waddr  (waddr),
		.stat   (stat),
		.sum    (sum),
		.min_col(min_col),
		.min_row(min_row),
		.crop_w (crop_w),
		.crop_h (crop_h)
	);

	// Read walk over the cropped rectangle
	assign rd_ok   = stat.frame_ready && stat.any_found && !read_done_q;
	assign col_end = ((CW+1)'(read_col_q) + (CW+1)'(1)) >= crop_w;
	assign row_end = ((RW+1)'(read_row_q) + (RW+1)'(1)) >= crop_h;
	assign raddr   = AW'(32'(min_row + read_row_q) * MAX_WIDTH + 32'(min_col + read_col_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_col_q  <= '0;
			read_row_q  <= '0;
			read_done_q <= 1'b0;
		end else if (load && sum.frame_end) begin
			read_col_q  <= '0;
			read_row_q  <= '0;
			read_done_q <= 1'b0;
		end else if (rd && rd_ok) begin
			if (!col_end) begin
				read_col_q <= read_col_q + CW'(1);
			end else begin
				read_col_q <= '0;
				if (row_end) read_done_q <= 1'b1;
				else read_row_q <= read_row_q + RW'(1);
			end
		end
	end

	mbbc_store #(
		.AW   (AW),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (load),
		.waddr(waddr),
		.wdata(req.pixel_in),
		.re   (rd && rd_ok),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Result stage, aligned with the RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			pix_s1  <= 1'b0;
		end else begin
			done_s1 <= rd || (load && sum.frame_end);
			pix_s1  <= rd && rd_ok;
		end
	end

	// Result fields for the request being taken
	always_comb begin
		res_nxt = '0;
		if (rd) begin
			res_nxt.kind   = KIND_PIXEL;
			res_nxt.status = rd_ok ? STATUS_OK : STATUS_EMPTY;
			res_nxt.last   = rd_ok && col_end && row_end;
		end else begin
			res_nxt.kind        = KIND_SUMMARY;
			res_nxt.found       = sum.found;
			res_nxt.crop_width  = sum.crop_width;
			res_nxt.crop_height = sum.crop_height;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= res_nxt;
	end

	always_comb begin
		result           = res_s1;
		result.pixel_out = pix_s1 ? rdata : 8'd0;
	end

	assign done = done_s1;

	// Only an accepted request can raise the strobe
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result strobe without a request");

	// Every read answers in the next cycle
	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		rd |=> done && result.kind == KIND_PIXEL)
		else $error("read request got no answer");

	// A found box never has zero size
	a_found_size: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.kind == KIND_SUMMARY && result.found |->
		result.crop_width != 9'd0 && result.crop_height != 9'd0)
		else $error("found box with zero size");

	// The last cropped pixel closes the walk
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.kind == KIND_PIXEL && result.last |-> read_done_q)
		else $error("last pixel without closing the walk");

endmodule

>>> hw/rtl/mbbc_store.sv
module mbbc_store import mbbc_pkg::*; #(
	parameter int AW    = 16,
	parameter int DEPTH = 65536
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/mbbc_box.sv
module mbbc_box import mbbc_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int CW = 8,
	parameter int RW = 8,
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic [7:0]    pixel,
	input  logic [7:0]    mask,
	input  logic [CW:0]   w_eff,
	input  logic [RW:0]   h_eff,
	output logic [AW-1:0] waddr,
	output box_stat_t     stat,
	output load_sum_t     sum,
	output logic [CW-1:0] min_col,
	output logic [RW-1:0] min_row,
	output logic [CW:0]   crop_w,
	output logic [RW:0]   crop_h
);

	logic [CW-1:0] col_q, min_col_q, max_col_q, min_col_nxt, max_col_nxt;
	logic [RW-1:0] row_q, min_row_q, max_row_q, min_row_nxt, max_row_nxt;
	logic          any_q, ready_q, any_nxt, base_found, first, hit;
	logic          end_row, end_frame;

	// Box update for the pixel at the load position
	always_comb begin
		first      = (col_q == '0) && (row_q == '0);
		base_found = first ? 1'b0 : any_q;
		hit        = (pixel != mask);
		any_nxt    = base_found | hit;
		min_col_nxt = min_col_q;
		max_col_nxt = max_col_q;
		min_row_nxt = min_row_q;
		max_row_nxt = max_row_q;
		if (hit) begin
			if (!base_found) begin
				min_col_nxt = col_q;
				max_col_nxt = col_q;
				min_row_nxt = row_q;
				max_row_nxt = row_q;
			end else begin
				if (col_q < min_col_q) min_col_nxt = col_q;
				if (col_q > max_col_q) max_col_nxt = col_q;
				if (row_q < min_row_q) min_row_nxt = row_q;
				if (row_q > max_row_q) max_row_nxt = row_q;
			end
		end
		end_row   = ((CW+1)'(col_q) + (CW+1)'(1)) >= w_eff;
		end_frame = end_row && (((RW+1)'(row_q) + (RW+1)'(1)) >= h_eff);
	end

	// Summary of the frame if this load ends it
	always_comb begin
		sum.frame_end   = end_frame;
		sum.found       = any_nxt;
		sum.crop_width  = '0;
		sum.crop_height = '0;
		if (any_nxt) begin
			sum.crop_width  = 9'(32'(max_col_nxt) - 32'(min_col_nxt) + 32'd1);
			sum.crop_height = 9'(32'(max_row_nxt) - 32'(min_row_nxt) + 32'd1);
		end
	end

	assign waddr = AW'(32'(row_q) * MAX_WIDTH + 32'(col_q));

	// Load position, box and frame flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '1;
			max_col_q <= '0;
			min_row_q <= '1;
			max_row_q <= '0;
			any_q     <= 1'b0;
			ready_q   <= 1'b0;
		end else if (load) begin
			min_col_q <= min_col_nxt;
			max_col_q <= max_col_nxt;
			min_row_q <= min_row_nxt;
			max_row_q <= max_row_nxt;
			any_q     <= any_nxt;
			if (!end_row) begin
				col_q <= col_q + CW'(1);
			end else begin
				col_q <= '0;
				row_q <= end_frame ? '0 : row_q + RW'(1);
			end
			if (end_frame) begin
				ready_q <= 1'b1;
			end else if (first) begin
				ready_q <= 1'b0;
			end
		end
	end

	assign stat.any_found   = any_q;
	assign stat.frame_ready = ready_q;
	assign min_col = min_col_q;
	assign min_row = min_row_q;
	assign crop_w  = (CW+1)'(max_col_q) - (CW+1)'(min_col_q) + (CW+1)'(1);
	assign crop_h  = (RW+1)'(max_row_q) - (RW+1)'(min_row_q) + (RW+1)'(1);

endmodule
